// ----- hw/rtl/ivs_pkg.sv -----
package ivs_pkg;

   // word and field widths
   localparam int DATA_W       = 64;
   localparam int OP_W         = 4;
   localparam int INDEX_W      = 8;
   localparam int LEN_W        = 9;
   localparam int CAPACITY_DEF = 256;

   // request codes
   typedef enum logic [OP_W-1:0] {
      OP_READ   = 4'd0,
      OP_WRITE  = 4'd1,
      OP_PUSH   = 4'd2,
      OP_POP    = 4'd3,
      OP_INSERT = 4'd4,
      OP_ERASE  = 4'd5,
      OP_RESIZE = 4'd6,
      OP_CLEAR  = 4'd7,
      OP_FRONT  = 4'd8,
      OP_BACK   = 4'd9
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // request payload
   typedef struct packed {
      logic [OP_W-1:0]    req_type;
      logic [INDEX_W-1:0] elem_index;
      logic [LEN_W-1:0]   new_length;
      logic [DATA_W-1:0]  elem_value;
   } req_type;

   // result payload
   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      status_type        status;
      logic [LEN_W-1:0]  length;
      logic              is_empty;
   } rsp_type;

endpackage

// ----- hw/rtl/ivs_mem.sv -----
module ivs_mem #(
   parameter int CAPACITY = ivs_pkg::CAPACITY_DEF,
   localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AddrW-1:0]          wr_addr,
   input  logic [ivs_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AddrW-1:0]          rd_addr,
   output logic [ivs_pkg::DATA_W-1:0] rd_data
);
   import ivs_pkg::*;

   logic [DATA_W-1:0] mem_ff [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ivs_ctrl.sv -----
module ivs_ctrl #(
   parameter int CAPACITY = ivs_pkg::CAPACITY_DEF,
   localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  ivs_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output ivs_pkg::rsp_type           rsp_payload,
   output logic                       mem_wr_en,
   output logic [AddrW-1:0]           mem_wr_addr,
   output logic [ivs_pkg::DATA_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [AddrW-1:0]           mem_rd_addr,
   input  logic [ivs_pkg::DATA_W-1:0] mem_rd_data
);
   import ivs_pkg::*;

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int CmpW = (CntW > LEN_W) ? CntW : LEN_W;
   localparam logic [CmpW-1:0] CapCmp = CmpW'(CAPACITY);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_EXEC      = 7'b0000010,
      S_READ_WAIT = 7'b0000100,
      S_ERASE     = 7'b0001000,
      S_INSERT    = 7'b0010000,
      S_FILL      = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0]   nlen_ff, nlen_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    ptr_ff, ptr_in;
   logic [AddrW-1:0]   wptr_ff, wptr_in;
   logic               pend_ff, pend_in;
   logic               more_ff, more_in;
   status_type         res_status_ff, res_status_in;
   logic [DATA_W-1:0]  res_rd_ff, res_rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CmpW-1:0] cnt_cmp, idx_cmp, nlen_cmp, ptr_cmp;
   logic [CntW-1:0] cnt_inc, cnt_dec, ptr_inc, ptr_dec, idx_inc;
   logic            cnt_zero, cnt_full, out_free;

   // compare operands brought to one width
   assign cnt_cmp  = CmpW'(count_ff);
   assign idx_cmp  = CmpW'(idx_ff);
   assign nlen_cmp = CmpW'(nlen_ff);
   assign ptr_cmp  = CmpW'(ptr_ff);
   assign cnt_inc  = count_ff + 1'b1;
   assign cnt_dec  = count_ff - 1'b1;
   assign ptr_inc  = ptr_ff + 1'b1;
   assign ptr_dec  = ptr_ff - 1'b1;
   assign idx_inc  = CntW'(idx_cmp + 1'b1);
   assign cnt_zero = (count_ff == '0);
   assign cnt_full = (cnt_cmp >= CapCmp);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: decode, then read-modify-write loops over the store
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      nlen_in       = nlen_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      wptr_in       = wptr_ff;
      pend_in       = 1'b0;
      more_in       = more_ff;
      res_status_in = res_status_ff;
      res_rd_in     = res_rd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wptr_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ptr_ff[AddrW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_payload.req_type;
               idx_in   = req_payload.elem_index;
               nlen_in  = req_payload.new_length;
               val_in   = req_payload.elem_value;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_rd_in     = '0;
            res_status_in = ST_OK;
            state_in      = S_DONE;
            unique case (op_ff) inside
               OP_READ, OP_WRITE, OP_ERASE: begin
                  if (cnt_zero) begin
                     res_status_in = ST_EMPTY;
                  end else if (idx_cmp >= cnt_cmp) begin
                     res_status_in = ST_RANGE;
                  end else if (op_ff == OP_READ) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = AddrW'(idx_ff);
                     state_in    = S_READ_WAIT;
                  end else if (op_ff == OP_WRITE) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AddrW'(idx_ff);
                     mem_wr_data = val_ff;
                  end else begin
                     ptr_in   = idx_inc;
                     state_in = S_ERASE;
                  end
               end
               OP_PUSH: begin
                  if (cnt_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = count_ff[AddrW-1:0];
                     mem_wr_data = val_ff;
                     count_in    = cnt_inc;
                  end
               end
               OP_POP: begin
                  if (cnt_zero) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     count_in = cnt_dec;
                  end
               end
               OP_INSERT: begin
                  if (idx_cmp > cnt_cmp) begin
                     res_status_in = ST_RANGE;
                  end else if (cnt_full) begin
                     res_status_in = ST_FULL;
                  end else if (idx_cmp == cnt_cmp) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AddrW'(idx_ff);
                     mem_wr_data = val_ff;
                     count_in    = cnt_inc;
                  end else begin
                     ptr_in   = cnt_dec;
                     more_in  = 1'b1;
                     state_in = S_INSERT;
                  end
               end
               OP_RESIZE: begin
                  if (nlen_cmp > CapCmp) begin
                     res_status_in = ST_FULL;
                  end else if (nlen_cmp <= cnt_cmp) begin
                     count_in = CntW'(nlen_cmp);
                  end else begin
                     ptr_in   = count_ff;
                     state_in = S_FILL;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               OP_FRONT, OP_BACK: begin
                  if (cnt_zero) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = (op_ff == OP_FRONT) ? '0 : cnt_dec[AddrW-1:0];
                     state_in    = S_READ_WAIT;
                  end
               end
               default: begin
               end
            endcase
         end

         S_READ_WAIT: begin
            res_rd_in = mem_rd_data;
            state_in  = S_DONE;
         end

         // move later elements down: read k+1, write k in the following cycle
         S_ERASE: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (ptr_cmp < cnt_cmp) begin
               mem_rd_en = 1'b1;
               pend_in   = 1'b1;
               wptr_in   = ptr_dec[AddrW-1:0];
               ptr_in    = ptr_inc;
            end else if (!pend_ff) begin
               count_in = cnt_dec;
               state_in = S_DONE;
            end
         end

         // move later elements up from the back, then drop the new word in
         S_INSERT: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (more_ff) begin
               mem_rd_en = 1'b1;
               pend_in   = 1'b1;
               wptr_in   = ptr_inc[AddrW-1:0];
               if (ptr_cmp == idx_cmp) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_dec;
               end
            end else if (!pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AddrW'(idx_ff);
               mem_wr_data = val_ff;
               count_in    = cnt_inc;
               state_in    = S_DONE;
            end
         end

         // fill the grown tail with the given word
         S_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff[AddrW-1:0];
            mem_wr_data = val_ff;
            if (CmpW'(ptr_inc) == nlen_cmp) begin
               count_in = CntW'(nlen_cmp);
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_inc;
            end
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.read_value  = res_rd_ff;
               rsp_in.status      = res_status_ff;
               rsp_in.length      = LEN_W'(count_ff);
               rsp_in.is_empty    = cnt_zero;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      nlen_ff       <= nlen_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      wptr_ff       <= wptr_in;
      res_status_ff <= res_status_in;
      res_rd_ff     <= res_rd_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // length never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_cmp <= CapCmp)
      else $error("element count above capacity");

   // shift loops never read and write one entry in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
      else $error("read and write to the same entry");

   // a finished result waits while the output register is still taken
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result dropped while output busy");

   // a refused request leaves the length alone
   a_refused_keeps_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && res_status_in != ST_OK) |=> (count_ff == $past(count_ff)))
      else $error("refused request changed the length");

endmodule

// ----- hw/rtl/indexed_vector_store_core.sv -----
// Ordered vector of 64-bit words in a single-port-write, registered-read store of
// CAPACITY entries, plus a length register. One request is worked on at a time; the
// result sits in an output register so the next request can be taken while it waits.
// Read, write, push, pop, clear, front and back finish without a loop over the store.
// Erase and insert at index i shift the later elements, and a growing resize fills
// the new positions with the given word: each moved or filled element takes one
// write on the store's write port. The store is not cleared after reset; only
// positions below the length are ever read.
module indexed_vector_store_core #(
   parameter int CAPACITY = ivs_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ivs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ivs_pkg::rsp_type rsp_payload
);
   import ivs_pkg::*;

   localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic              mem_wr_en;
   logic [AddrW-1:0]  mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AddrW-1:0]  mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   // request sequencer and result register
   ivs_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // element store
   ivs_mem #(
      .CAPACITY (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- bench/indexed_vector_store_core_test.sv -----
`timescale 1ns / 1ps

module indexed_vector_store_core_test;
   import ivs_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 50;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // shadow copy of the vector, updated at each request transfer
   logic [DATA_W-1:0] shadow_words [CAPACITY_DEF];
   int                shadow_len = 0;

   rsp_type vector_replies [$];
   int      error_count       = 0;
   int      quiet_cycles      = 0;
   int      sender_idle_pct   = 0;
   int      receiver_idle_pct = 0;

   indexed_vector_store_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // apply one request to the shadow vector and build the reply it should give
   function automatic rsp_type apply_vector_op(input req_type item);
      rsp_type reply;
      int      idx;
      int      nlen;
      int      k;
      reply        = '0;
      reply.status = ST_OK;
      idx          = int'(item.elem_index);
      nlen         = int'(item.new_length);
      case (op_type'(item.req_type)) inside
         OP_READ, OP_WRITE, OP_ERASE: begin
            if (shadow_len == 0) begin
               reply.status = ST_EMPTY;
            end else if (idx >= shadow_len) begin
               reply.status = ST_RANGE;
            end else if (item.req_type == OP_READ) begin
               reply.read_value = shadow_words[idx];
            end else if (item.req_type == OP_WRITE) begin
               shadow_words[idx] = item.elem_value;
            end else begin
               // later elements move down one place
               for (k = idx; k + 1 < shadow_len; k++)
                  shadow_words[k] = shadow_words[k + 1];
               shadow_len--;
            end
         end
         OP_PUSH: begin
            if (shadow_len >= CAPACITY_DEF) begin
               reply.status = ST_FULL;
            end else begin
               shadow_words[shadow_len] = item.elem_value;
               shadow_len++;
            end
         end
         OP_POP: begin
            if (shadow_len == 0) reply.status = ST_EMPTY;
            else shadow_len--;
         end
         OP_INSERT: begin
            // range is checked before fullness
            if (idx > shadow_len) begin
               reply.status = ST_RANGE;
            end else if (shadow_len >= CAPACITY_DEF) begin
               reply.status = ST_FULL;
            end else begin
               for (k = shadow_len; k > idx; k--)
                  shadow_words[k] = shadow_words[k - 1];
               shadow_words[idx] = item.elem_value;
               shadow_len++;
            end
         end
         OP_RESIZE: begin
            if (nlen > CAPACITY_DEF) begin
               reply.status = ST_FULL;
            end else begin
               // growing fills new positions, shrinking only cuts the length
               for (k = shadow_len; k < nlen; k++)
                  shadow_words[k] = item.elem_value;
               shadow_len = nlen;
            end
         end
         OP_CLEAR: begin
            shadow_len = 0;
         end
         OP_FRONT, OP_BACK: begin
            if (shadow_len == 0) reply.status = ST_EMPTY;
            else if (item.req_type == OP_FRONT) reply.read_value = shadow_words[0];
            else reply.read_value = shadow_words[shadow_len - 1];
         end
         default: begin
            // unknown request codes change nothing
         end
      endcase
      reply.length   = LEN_W'(shadow_len);
      reply.is_empty = (shadow_len == 0);
      return reply;
   endfunction

   // one request transfer; valid stays high between back-to-back requests
   task automatic send_request(input logic [OP_W-1:0] op, input int idx, input int nlen,
                               input logic [DATA_W-1:0] value);
      req_type item;
      item.req_type   = op;
      item.elem_index = INDEX_W'(idx);
      item.new_length = LEN_W'(nlen);
      item.elem_value = value;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      vector_replies = {vector_replies, apply_vector_op(item)};
   endtask

   // refusals on an empty vector
   task automatic test_empty_vector();
      send_request(OP_READ, 0, 0, '0);
      send_request(OP_WRITE, 0, 0, '1);
      send_request(OP_ERASE, 0, 0, '0);
      send_request(OP_POP, 0, 0, '0);
      send_request(OP_FRONT, 0, 0, '0);
      send_request(OP_BACK, 0, 0, '0);
      send_request(OP_INSERT, 1, 0, '1);
      send_request(OP_RESIZE, 0, 511, '1);
   endtask

   // editing a short vector, including range refusals and both resize directions
   task automatic test_short_vector_edits();
      send_request(OP_PUSH, 0, 0, 64'h0);
      send_request(OP_PUSH, 0, 0, '1);
      send_request(OP_INSERT, 1, 0, 64'hA5A5_5A5A_0F0F_F0F0);
      send_request(OP_INSERT, 3, 0, 64'h8000_0000_0000_0001);
      send_request(OP_INSERT, 5, 0, 64'h1234);
      send_request(OP_WRITE, 0, 0, 64'hDEAD_BEEF_CAFE_F00D);
      send_request(OP_FRONT, 0, 0, '0);
      send_request(OP_BACK, 0, 0, '0);
      send_request(OP_ERASE, 0, 0, '0);
      send_request(OP_ERASE, 2, 0, '0);
      send_request(OP_RESIZE, 0, 1, '1);
      send_request(OP_RESIZE, 0, 6, 64'h7777_0000_7777_0000);
      send_request(OP_READ, 5, 0, '0);
      send_request(OP_READ, 255, 0, '0);
      send_request(OP_CLEAR, 0, 0, '0);
   endtask

   // a vector at capacity: full refusals and the longest shifts
   task automatic test_full_vector();
      send_request(OP_RESIZE, 0, CAPACITY_DEF, 64'h5555_AAAA_5555_AAAA);
      send_request(OP_PUSH, 0, 0, '1);
      send_request(OP_INSERT, 255, 0, '1);
      send_request(OP_READ, 255, 0, '0);
      send_request(OP_ERASE, 0, 0, '0);
      send_request(OP_INSERT, 0, 0, 64'h0123_4567_89AB_CDEF);
      send_request(OP_RESIZE, 0, CAPACITY_DEF + 1, '0);
      send_request(OP_CLEAR, 0, 0, '0);
   endtask

   // random mix, mostly well-formed indices on small vectors, some stray codes
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count);
      int               pick;
      int               idx;
      int               nlen;
      logic [OP_W-1:0]  op;
      logic [DATA_W-1:0] value;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         pick  = $urandom_range(99);
         value = {$urandom, $urandom};
         nlen  = $urandom_range(511);
         idx   = (shadow_len == 0) ? $urandom_range(3) : $urandom_range(shadow_len - 1);
         if      (pick < 12) op = OP_READ;
         else if (pick < 22) op = OP_WRITE;
         else if (pick < 36) op = OP_PUSH;
         else if (pick < 46) op = OP_POP;
         else if (pick < 58) begin
            op  = OP_INSERT;
            idx = $urandom_range(shadow_len > 255 ? 255 : shadow_len);
         end
         else if (pick < 68) op = OP_ERASE;
         else if (pick < 74) begin
            op = OP_RESIZE;
            case ($urandom_range(7))
               0:       nlen = $urandom_range(CAPACITY_DEF - 56, CAPACITY_DEF);
               1:       nlen = $urandom_range(CAPACITY_DEF + 1, 511);
               default: nlen = $urandom_range(24);
            endcase
         end
         else if (pick < 77) op = OP_CLEAR;
         else if (pick < 83) op = OP_FRONT;
         else if (pick < 89) op = OP_BACK;
         else if (pick < 94) op = OP_W'($urandom_range(10, 15));
         else begin
            op  = OP_W'($urandom_range(15));
            idx = $urandom_range(255);
         end
         // some indices land anywhere in the field
         if (pick < 94 && $urandom_range(9) < 2) idx = $urandom_range(255);
         send_request(op, idx, nlen, value);
      end
   endtask

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // compare each result transfer with the oldest awaited reply
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vector_replies.size() == 0) begin
            $error("result transfer with no request outstanding: %h", rsp_payload);
            error_count++;
         end else begin
            want = vector_replies.pop_front();
            if (rsp_payload.read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value,
                      rsp_payload.read_value);
               error_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_payload.length);
               error_count++;
            end
            if (rsp_payload.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0b, got %0b", want.is_empty,
                      rsp_payload.is_empty);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_vector_store_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_vector();
      test_short_vector_edits();
      test_full_vector();
      test_random_traffic(22, 59, 540);
      test_random_traffic(59, 22, 540);
      test_random_traffic(0, 0, 540);
      req_valid <= 1'b0;
      // drain outstanding replies, then watch for stray transfers
      while (vector_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("indexed_vector_store_core verification clean");
      end else begin
         $display("indexed_vector_store_core verification failed");
      end
      $finish;
   end

endmodule
